// ===== hdl/lkv_pkg.sv =====
package lkv_pkg;

  localparam int ENTRIES     = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;

  // age of an entry, 0 is the most recent
  localparam int AGE_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  // occupancy and effective capacity, 0 .. ENTRIES
  localparam int CNT_W = $clog2(ENTRIES + 1);
  // capacity register as seen on the bus
  localparam int CAP_W = 5;
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);

  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  typedef enum logic {
    REG_CAPACITY = 1'b0,
    REG_NONE     = 1'b1
  } reg_index_e;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_e;

  typedef struct packed {
    logic                          kind;
    logic [KEY_WIDTH-1:0]          lookup_key;
    logic signed [VALUE_WIDTH-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic                          hit;
    logic signed [VALUE_WIDTH-1:0] read_value;
    logic [KEY_WIDTH-1:0]          recent_key;
    logic                          recent_valid;
  } rsp_t;

  typedef struct packed {
    logic             go;
    logic [CNT_W-1:0] cap;
  } core_ctrl_t;

endpackage

// ===== hdl/lkv_req_if.sv =====
interface lkv_req_if import lkv_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/lkv_rsp_if.sv =====
interface lkv_rsp_if import lkv_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/lkv_core.sv =====
module lkv_core import lkv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  core_ctrl_t ctrl_i,
  input  req_t       req_i,
  output rsp_t       rsp_o
);

  logic [KEY_WIDTH-1:0]   key_q   [ENTRIES];
  logic [VALUE_WIDTH-1:0] value_q [ENTRIES];
  logic [AGE_W-1:0]       age_q   [ENTRIES];
  logic [AGE_W-1:0]       age_d   [ENTRIES];
  logic [ENTRIES-1:0]     valid_q, valid_d;
  logic [CNT_W-1:0]       occ_q, occ_d;
  logic [KEY_WIDTH-1:0]   recent_q, recent_d;

  logic [ENTRIES-1:0]     match, hit_oh, free_oh, old_vec, old_oh, sel_oh, wr_key_oh, wr_val_oh;
  logic [AGE_W-1:0]       hit_age;
  logic [VALUE_WIDTH-1:0] hit_value;
  logic [CNT_W-1:0]       from, occ_m1;
  logic                   found, do_touch;

  function automatic logic [ENTRIES-1:0] lowest_oh(input logic [ENTRIES-1:0] v);
    return v & (~v + ENTRIES'(1));
  endfunction

  always_comb begin
    occ_m1 = occ_q - CNT_W'(1);
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]   = valid_q[i] && (key_q[i] == req_i.lookup_key);
      old_vec[i] = valid_q[i] && (occ_q != '0) && (CNT_W'(age_q[i]) == occ_m1);
    end
    hit_oh  = lowest_oh(match);
    free_oh = lowest_oh(~valid_q);
    old_oh  = lowest_oh(old_vec);
    found   = |match;

    hit_age   = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_oh[i]) begin
        hit_age   = hit_age | age_q[i];
        hit_value = hit_value | value_q[i];
      end
    end
  end

  // slot choice and bookkeeping for one item
  always_comb begin
    sel_oh    = '0;
    wr_key_oh = '0;
    wr_val_oh = '0;
    from      = '0;
    do_touch  = 1'b0;
    occ_d     = occ_q;
    valid_d   = valid_q;
    recent_d  = recent_q;
    if (ctrl_i.go) begin
      if (found) begin
        sel_oh   = hit_oh;
        from     = CNT_W'(hit_age);
        do_touch = 1'b1;
        if (req_i.kind == KIND_INSERT) begin
          wr_val_oh = hit_oh;
        end
      end else if (req_i.kind == KIND_INSERT) begin
        do_touch = 1'b1;
        if ((occ_q < ctrl_i.cap) && (|free_oh)) begin
          sel_oh = free_oh;
          from   = occ_q;
          occ_d  = occ_q + CNT_W'(1);
        end else if (|old_oh) begin
          // full: reuse the slot of the oldest entry
          sel_oh = old_oh;
          from   = occ_m1;
        end else begin
          sel_oh = ENTRIES'(1);
          occ_d  = CNT_W'(1);
        end
        wr_key_oh = sel_oh;
        wr_val_oh = sel_oh;
        valid_d   = valid_q | sel_oh;
      end
      if (do_touch) begin
        recent_d = req_i.lookup_key;
      end
    end

    for (int i = 0; i < ENTRIES; i++) begin
      age_d[i] = age_q[i];
      if (do_touch) begin
        if (sel_oh[i]) begin
          age_d[i] = '0;
        end else if (valid_q[i] && (CNT_W'(age_q[i]) < from)) begin
          age_d[i] = age_q[i] + AGE_W'(1);
        end
      end
    end
  end

  always_comb begin
    rsp_o.hit          = found;
    rsp_o.read_value   = (found && req_i.kind == KIND_LOOKUP) ? hit_value : '0;
    rsp_o.recent_valid = (occ_d != '0);
    rsp_o.recent_key   = recent_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      occ_q    <= '0;
      recent_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        age_q[i] <= '0;
      end
    end else begin
      valid_q  <= valid_d;
      occ_q    <= occ_d;
      recent_q <= recent_d;
      for (int i = 0; i < ENTRIES; i++) begin
        age_q[i] <= age_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (wr_key_oh[i]) begin
        key_q[i] <= req_i.lookup_key;
      end
      if (wr_val_oh[i]) begin
        value_q[i] <= req_i.write_value;
      end
    end
  end

endmodule

// ===== hdl/lru_key_value_cache.sv =====
// channel   dir  transfer when        payload
// req_i     in   valid && ready       kind, lookup_key, write_value
// rsp_o     out  valid && ready       hit, read_value, recent_key, recent_valid
// apb       in   psel&penable&pwrite  capacity at byte address 0
//
// one item per cycle sustained while results are taken; the item is held in the input register and
// its result is written to the output register once that has room, and offered from there
// the parallel key compare and age update over all entries lie between the two registers
// reset clears valid bits, ages, occupancy and sets capacity to 16, no clearing pass
// a stalled result holds in the output register; one more item waits in the input
// register, then req_i.ready drops until the result is taken
module lru_key_value_cache import lkv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  lkv_req_if.sink           req_i,
  lkv_rsp_if.source         rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // capacity register and its clamped form
  logic [CAP_W-1:0] cap_q, cap_d;
  logic [CMP_W-1:0] cap_ext;
  logic [CNT_W-1:0] cap_eff;
  reg_index_e       reg_sel;

  // input register: the item being worked on this cycle
  logic in_valid_q, in_valid_d;
  req_t in_req_q;

  // output register: the finished result
  logic out_valid_q, out_valid_d;
  rsp_t out_rsp_q;

  logic       req_xfer, advance;
  core_ctrl_t core_ctrl;
  rsp_t       core_rsp;

  // ---------------------------------------------------------------- config port
  // register index is the word address; anything past register 0 reads zero
  assign reg_sel = reg_index_e'(paddr[2]);
  assign pready  = 1'b1;

  always_comb begin
    cap_d = cap_q;
    if (psel && penable && pwrite && reg_sel == REG_CAPACITY) begin
      cap_d = pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    case (reg_sel)
      REG_CAPACITY: prdata = DATA_W'(cap_q);
      default:      prdata = '0;
    endcase
  end

  // zero acts as one, anything above the entry count saturates
  always_comb begin
    cap_ext = CMP_W'(cap_q);
    if (cap_ext == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      cap_eff = CNT_W'(ENTRIES);
    end else begin
      cap_eff = cap_ext[CNT_W-1:0];
    end
  end

  // ---------------------------------------------------------------- handshake
  // the held item is processed once the output register has room for its result
  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;
  assign req_xfer    = req_i.valid && req_i.ready;

  always_comb begin
    in_valid_d = req_xfer || (in_valid_q && !advance);
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign core_ctrl.go  = advance;
  assign core_ctrl.cap = cap_eff;

  // cache state and the whole lookup/insert/age update for one item
  lkv_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (core_ctrl),
    .req_i  (in_req_q),
    .rsp_o  (core_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAPACITY_RESET;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cap_q       <= cap_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      in_req_q <= req_i.payload;
    end
    if (advance) begin
      out_rsp_q <= core_rsp;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_rsp_q;

endmodule

// ===== test/tb_lru_key_value_cache.sv =====
`timescale 1ns / 1ps

module tb_lru_key_value_cache;
  import lkv_pkg::*;

  localparam int IDLE_LIMIT  = 1000;  // cycles with no transfer before giving up
  localparam int HOLD_CYCLES = 80;    // long receiver hold-off
  localparam logic [ADDR_W-1:0] CAPACITY_ADDR = ADDR_W'(int'(REG_CAPACITY) * 4);

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  lkv_req_if req_bus ();
  lkv_rsp_if rsp_bus ();

  lru_key_value_cache u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_bus),
    .rsp_o   (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow copy of the cache contents, kept in step with every request transfer
  logic [KEY_WIDTH-1:0]   shadow_key   [ENTRIES];
  logic [VALUE_WIDTH-1:0] shadow_value [ENTRIES];
  logic                   shadow_valid [ENTRIES];
  logic [AGE_W-1:0]       shadow_age   [ENTRIES];
  int                     shadow_count;
  logic [CAP_W-1:0]       shadow_capacity;

  req_t req_backlog[$];       // requests waiting to be offered
  rsp_t expected_replies[$];  // predicted responses, oldest first

  // traffic shaping, set per phase by the sequencer
  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_requests;
  int  hold_served;
  int  hold_left;
  bit  req_taken;

  int  error_count;
  int  stall_cycles;
  int  insert_count;
  int  lookup_count;
  int  hit_count;
  int  setting_count;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  // age every valid entry younger than 'from' by one, then make slot s the newest
  function automatic void promote_entry(input int s, input int from);
    for (int i = 0; i < ENTRIES; i++) begin
      if (shadow_valid[i] && i != s && int'(shadow_age[i]) < from) begin
        shadow_age[i] = shadow_age[i] + 1'b1;
      end
    end
    shadow_age[s] = '0;
  endfunction

  // apply one request to the shadow cache and return the response it must produce
  function automatic rsp_t cache_access(input req_t r);
    rsp_t res;
    int   found;
    int   slot;
    int   eff_cap;
    int   from;
    int   oldest;
    res     = '0;
    found   = -1;
    slot    = -1;
    eff_cap = int'(shadow_capacity);
    if (eff_cap < 1) eff_cap = 1;
    if (eff_cap > ENTRIES) eff_cap = ENTRIES;

    // lowest matching slot wins
    for (int i = 0; i < ENTRIES; i++) begin
      if (found < 0 && shadow_valid[i] && shadow_key[i] == r.lookup_key) found = i;
    end

    if (r.kind == KIND_LOOKUP) begin
      if (found >= 0) begin
        res.read_value = shadow_value[found];
        promote_entry(found, int'(shadow_age[found]));
      end
    end else if (found >= 0) begin
      shadow_value[found] = r.write_value;
      promote_entry(found, int'(shadow_age[found]));
    end else begin
      from = shadow_count;
      if (shadow_count < eff_cap) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot < 0 && !shadow_valid[i]) slot = i;
        end
      end
      if (slot >= 0) begin
        shadow_count++;
      end else begin
        // full (or over capacity after a lowering): reuse the oldest slot
        oldest = 0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (shadow_valid[i] && (slot < 0 || int'(shadow_age[i]) > oldest)) begin
            slot   = i;
            oldest = int'(shadow_age[i]);
          end
        end
        if (slot < 0) begin
          slot         = 0;
          shadow_count = 1;
          oldest       = 0;
        end
        from = oldest;
      end
      shadow_key[slot]   = r.lookup_key;
      shadow_value[slot] = r.write_value;
      shadow_valid[slot] = 1'b1;
      promote_entry(slot, from);
    end

    for (int i = 0; i < ENTRIES; i++) begin
      if (!res.recent_valid && shadow_valid[i] && shadow_age[i] == '0) begin
        res.recent_key   = shadow_key[i];
        res.recent_valid = 1'b1;
      end
    end
    res.hit = (found >= 0);
    return res;
  endfunction

  // request driver: new values at the falling edge, a shown request holds until taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
    end else if (!req_bus.valid || req_taken) begin
      if (req_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        req_bus.valid   <= 1'b1;
        req_bus.payload <= req_backlog.pop_front();
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // response ready: random stalls, plus a long hold-off counted here on request
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      rsp_bus.ready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (rst_ni && hold_served != hold_requests) begin
      rsp_bus.ready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      hold_served   <= hold_served + 1;
    end else begin
      rsp_bus.ready <= rst_ni && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // monitor: check responses first, then predict the request taken at this edge
  always @(posedge clk_i) begin
    rsp_t want;
    bit   req_xfer;
    bit   rsp_xfer;
    bit   cfg_xfer;
    req_xfer  = rst_ni && req_bus.valid && req_bus.ready;
    rsp_xfer  = rst_ni && rsp_bus.valid && rsp_bus.ready;
    cfg_xfer  = rst_ni && psel && penable && pwrite && pready;
    req_taken <= req_xfer;

    if (rsp_xfer) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("unexpected response", 64'(rsp_bus.payload), '0);
      end else begin
        want = expected_replies.pop_front();
        if (rsp_bus.payload.hit !== want.hit)
          report_mismatch("hit", 64'(rsp_bus.payload.hit), 64'(want.hit));
        if (rsp_bus.payload.read_value !== want.read_value)
          report_mismatch("read_value", 64'(rsp_bus.payload.read_value),
                          64'(want.read_value));
        if (rsp_bus.payload.recent_key !== want.recent_key)
          report_mismatch("recent_key", 64'(rsp_bus.payload.recent_key),
                          64'(want.recent_key));
        if (rsp_bus.payload.recent_valid !== want.recent_valid)
          report_mismatch("recent_valid", 64'(rsp_bus.payload.recent_valid),
                          64'(want.recent_valid));
        if (want.hit) hit_count++;
      end
    end

    if (req_xfer) begin
      if (req_bus.payload.kind == KIND_LOOKUP) lookup_count++;
      else insert_count++;
      expected_replies.push_back(cache_access(req_bus.payload));
    end

    if (cfg_xfer && paddr == CAPACITY_ADDR) shadow_capacity = pwdata[CAP_W-1:0];

    if (!rst_ni || req_xfer || rsp_xfer || cfg_xfer) stall_cycles = 0;
    else stall_cycles++;
  end

  // watchdog: a long stretch with no transfer of any kind ends the run
  initial begin
    stall_cycles = 0;
    while (stall_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("no transfer for %0d cycles, %0d responses outstanding",
             IDLE_LIMIT, expected_replies.size());
    $display("TEST FAILED");
    $finish;
  end

  function automatic req_t make_req(input kind_e kind, input logic [KEY_WIDTH-1:0] key,
                                    input logic [VALUE_WIDTH-1:0] value);
    req_t r;
    r.kind        = kind;
    r.lookup_key  = key;
    r.write_value = value;
    return r;
  endfunction

  // every queued request offered, taken and answered; checked at the rising edge,
  // where the driver never moves the backlog or valid
  task automatic wait_drained();
    while (req_backlog.size() > 0 || req_bus.valid || expected_replies.size() > 0)
      @(posedge clk_i);
  endtask

  // apb write of the capacity register, then read it back
  task automatic write_capacity(input logic [CAP_W-1:0] cap_val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAPACITY_ADDR;
    pwdata  <= DATA_W'(cap_val);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== DATA_W'(cap_val))
      report_mismatch("capacity readback", 64'(prdata), 64'(cap_val));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    setting_count++;
  endtask

  // settle, reprogram, then fill the backlog with traffic over a small key pool
  task automatic run_random_phase(input logic [CAP_W-1:0] cap_val, input int count,
                                  input int mode, input bit squeeze);
    logic [KEY_WIDTH-1:0]   pool[$];
    logic [KEY_WIDTH-1:0]   key;
    logic [VALUE_WIDTH-1:0] value;
    kind_e                  kind;
    int                     eff_cap;
    int                     pick;
    wait_drained();
    repeat (2) @(negedge clk_i);
    write_capacity(cap_val);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
      default: begin send_idle_pct = 35; recv_stall_pct = 35; end
    endcase
    if (squeeze) send_idle_pct = 0;

    eff_cap = int'(cap_val);
    if (eff_cap < 1) eff_cap = 1;
    if (eff_cap > ENTRIES) eff_cap = ENTRIES;
    // a pool a little larger than the capacity gives both hits and evictions
    repeat (eff_cap + $urandom_range(1, 4)) pool.push_back($urandom);

    repeat (count) begin
      kind = $urandom_range(0, 1) ? KIND_LOOKUP : KIND_INSERT;
      pick = $urandom_range(0, 99);
      if (pick < 85) key = pool[$urandom_range(0, pool.size() - 1)];
      else if (pick < 95) key = $urandom;
      else key = $urandom_range(0, 1) ? '0 : '1;
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: value = 32'h8000_0000;
          1: value = 32'h7fff_ffff;
          2: value = '0;
          default: value = '1;
        endcase
      end else begin
        value = $urandom;
      end
      req_backlog.push_back(make_req(kind, key, value));
    end
    if (squeeze) hold_requests++;
    wait_drained();
  endtask

  initial begin
    logic [CAP_W-1:0] phase_caps[8];
    error_count     = 0;
    insert_count    = 0;
    lookup_count    = 0;
    hit_count       = 0;
    setting_count   = 0;
    hold_requests   = 0;
    hold_served     = 0;
    hold_left       = 0;
    req_taken       = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    req_bus.valid   = 1'b0;
    req_bus.payload = '0;
    rsp_bus.ready   = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    shadow_count    = 0;
    shadow_capacity = CAPACITY_RESET;
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_key[i]   = '0;
      shadow_value[i] = '0;
      shadow_valid[i] = 1'b0;
      shadow_age[i]   = '0;
    end

    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part at the reset capacity
    // lookup on an empty cache: miss, no recent key
    req_backlog.push_back(make_req(KIND_LOOKUP, 32'h0, 32'h0));
    req_backlog.push_back(make_req(KIND_INSERT, 32'h0, 32'h8000_0000));
    req_backlog.push_back(make_req(KIND_INSERT, 32'hffff_ffff, 32'h7fff_ffff));
    req_backlog.push_back(make_req(KIND_LOOKUP, 32'h0, 32'h0));
    req_backlog.push_back(make_req(KIND_LOOKUP, 32'hffff_ffff, 32'h0));
    // update of a present key answers with a zero value
    req_backlog.push_back(make_req(KIND_INSERT, 32'h0, 32'hffff_ffff));
    req_backlog.push_back(make_req(KIND_LOOKUP, 32'h0, 32'h1234_5678));
    // miss leaves the ages alone, write_value is ignored
    req_backlog.push_back(make_req(KIND_LOOKUP, 32'h5a5a_5a5a, 32'h1234_5678));
    // fill all entries
    for (int k = 1; k <= ENTRIES - 2; k++)
      req_backlog.push_back(make_req(KIND_INSERT, 32'(k), 32'(k * 3)));
    wait_drained();

    // capacity dropped below occupancy: each insert miss swaps out the oldest only
    write_capacity(CAP_W'(3));
    req_backlog.push_back(make_req(KIND_INSERT, 32'hdead_0001, 32'h11));
    req_backlog.push_back(make_req(KIND_INSERT, 32'hdead_0002, 32'h22));
    req_backlog.push_back(make_req(KIND_LOOKUP, 32'h0, 32'h0));
    req_backlog.push_back(make_req(KIND_LOOKUP, 32'h1, 32'h0));
    wait_drained();

    // zero capacity behaves as one
    write_capacity(CAP_W'(0));
    req_backlog.push_back(make_req(KIND_INSERT, 32'hbeef_0000, 32'h33));
    req_backlog.push_back(make_req(KIND_LOOKUP, 32'hbeef_0000, 32'h0));
    wait_drained();

    // random phases over a spread of capacities, including the saturating codes 17 and 31
    phase_caps = '{CAP_W'(1), CAP_W'(0), CAP_W'(4), CAP_W'(31),
                   CAP_W'(16), CAP_W'(2), CAP_W'(17), CAP_W'(9)};
    for (int p = 0; p < 8; p++)
      run_random_phase(phase_caps[p], 48, p % 4, p == 4);

    repeat (4) @(posedge clk_i);
    $display("ran %0d inserts and %0d lookups with %0d hits", insert_count, lookup_count,
             hit_count);
    $display("across %0d capacity settings, all idle/stall mixes and one long back-pressure",
             setting_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
